// File: src/hall_six_step_test_monitor_assert.svh
// Assertion helpers for the test monitor; they sample on clk and are off during reset.
`ifndef HALL_SIX_STEP_TEST_MONITOR_ASSERT_SVH
`define HALL_SIX_STEP_TEST_MONITOR_ASSERT_SVH

// cons must hold in the same cycle as ante
`define HSSM_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// cons must hold in the cycle after ante
`define HSSM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/hssm_pkg.sv
package hssm_pkg;

    localparam int unsigned CUR_W      = 16;
    localparam int unsigned HALL_W     = 3;
    localparam int unsigned STAT_W     = 3;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned QUO_W      = 16;

    typedef logic [CUR_W-1:0]      cur_t;
    typedef logic [HALL_W-1:0]     hall_t;
    typedef logic [STAT_W-1:0]     status_t;
    typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
    typedef logic [CFG_DATA_W-1:0] cfg_data_t;

    // configuration register indexes
    localparam cfg_idx_t CFG_DUTY   = 2'd0;
    localparam cfg_idx_t CFG_LIMIT  = 2'd1;
    localparam cfg_idx_t CFG_LENGTH = 2'd2;

    // run status codes
    localparam status_t ST_IDLE    = 3'd0;
    localparam status_t ST_RUN     = 3'd1;
    localparam status_t ST_TRIP    = 3'd2;
    localparam status_t ST_BADHALL = 3'd3;
    localparam status_t ST_DONE    = 3'd4;

    localparam cur_t DUTY_MAX     = 16'd32768;
    localparam cur_t LIMIT_RESET  = 16'd10000;
    localparam cur_t LENGTH_RESET = 16'd1000;

    typedef struct packed {
        logic start;
    } div_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// File: src/hssm_if.sv
interface hssm_sample_if;
    import hssm_pkg::*;

    logic  valid;
    logic  ready;
    logic  start_run;
    hall_t hall_pattern;
    cur_t  phase_current_ma;

    modport source (output valid, start_run, hall_pattern, phase_current_ma, input ready);
    modport sink   (input valid, start_run, hall_pattern, phase_current_ma, output ready);
endinterface

interface hssm_result_if;
    import hssm_pkg::*;

    logic    valid;
    logic    ready;
    cur_t    drive_a;
    cur_t    drive_b;
    cur_t    drive_c;
    status_t run_status;
    cur_t    peak_current_ma;
    cur_t    mean_current_ma;
    logic    all_halls_moved;
    hall_t   stuck_halls;

    modport source (output valid, drive_a, drive_b, drive_c, run_status, peak_current_ma,
                    mean_current_ma, all_halls_moved, stuck_halls, input ready);
    modport sink   (input valid, drive_a, drive_b, drive_c, run_status, peak_current_ma,
                    mean_current_ma, all_halls_moved, stuck_halls, output ready);
endinterface

interface hssm_cfg_if;
    import hssm_pkg::*;

    logic      valid;
    logic      ready;
    cfg_idx_t  index;
    cfg_data_t data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: src/hssm_div.sv
module hssm_div #(
    parameter int unsigned DEN_W = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  hssm_pkg::div_ctl_t              ctl,
    output hssm_pkg::div_stat_t             stat,
    input  logic [DEN_W+hssm_pkg::QUO_W-1:0] dividend,
    input  logic [DEN_W-1:0]                divisor,
    output logic [hssm_pkg::QUO_W-1:0]      quotient
);
    import hssm_pkg::*;

    localparam int unsigned CNT_W = $clog2(QUO_W + 1);

    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [QUO_W-1:0] low_reg, low_next;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    // restoring division, one quotient bit per cycle; the quotient is known to fit QUO_W bits
    always_comb
    begin
        trial    = {rem_reg, low_reg[QUO_W-1]};
        diff     = trial - {1'b0, den_reg};
        ge       = trial >= {1'b0, den_reg};
        rem_next = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        low_next = {low_reg[QUO_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctl.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(QUO_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            rem_reg <= dividend[DEN_W+QUO_W-1:QUO_W];
            low_reg <= dividend[QUO_W-1:0];
            den_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            low_reg <= low_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = low_reg;

endmodule

// File: src/hall_six_step_test_monitor.sv
// Each sample passes through the item registers, the step evaluation in S_EXEC and the output registers in S_LOAD;
// the step that completes a run also waits in S_DIV for the serial mean divider, and S_LOAD waits for the output.
// A new sample is taken only in S_IDLE, once the previous one has been loaded into the output registers.
// Reset: registers take their reset values, run idle, accumulators cleared, no result pending.
`include "hall_six_step_test_monitor_assert.svh"

module hall_six_step_test_monitor #(
    parameter int unsigned COUNT_BITS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    hssm_sample_if.sink   sample,
    hssm_result_if.source result,
    hssm_cfg_if.sink      cfg
);
    import hssm_pkg::*;

    localparam int unsigned SUM_W = CUR_W + COUNT_BITS;
    localparam int unsigned CMP_W = (COUNT_BITS > CUR_W) ? COUNT_BITS : CUR_W;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_LOAD = 2'd3;

    logic [1:0]            state_reg, state_next;

    cur_t                  duty_reg;
    cur_t                  limit_reg;
    cur_t                  length_reg;

    logic                  start_item_reg;
    hall_t                 hall_item_reg;
    cur_t                  cur_item_reg;

    logic                  run_active_reg, run_active_next;
    hall_t                 initial_hall_reg, initial_hall_next;
    hall_t                 hall_moved_reg, hall_moved_next;
    cur_t                  peak_reg, peak_next;
    logic [SUM_W-1:0]      sum_reg, sum_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;

    cur_t                  res_drive_a_reg, res_drive_a_next;
    cur_t                  res_drive_b_reg, res_drive_b_next;
    cur_t                  res_drive_c_reg, res_drive_c_next;
    status_t               res_status_reg, res_status_next;

    logic                  out_valid_reg;
    cur_t                  out_drive_a_reg;
    cur_t                  out_drive_b_reg;
    cur_t                  out_drive_c_reg;
    status_t               out_status_reg;
    cur_t                  out_peak_reg;
    cur_t                  out_mean_reg;
    hall_t                 out_moved_reg;

    logic                  act_eff;
    hall_t                 init_eff;
    hall_t                 moved_eff;
    cur_t                  peak_eff;
    logic [SUM_W-1:0]      sum_eff;
    logic [COUNT_BITS-1:0] count_eff;
    logic [COUNT_BITS-1:0] count_upd;
    cur_t                  duty;
    logic                  trip;
    logic                  length_hit;
    logic                  finish;
    logic                  load_out;

    div_ctl_t              div_ctl;
    div_stat_t             div_stat;
    logic [QUO_W-1:0]      quotient;

    // configuration
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            duty_reg   <= '0;
            limit_reg  <= LIMIT_RESET;
            length_reg <= LENGTH_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_DUTY:   duty_reg   <= cfg.data;
                CFG_LIMIT:  limit_reg  <= cfg.data;
                CFG_LENGTH: length_reg <= cfg.data;
                default:    ;
            endcase
        end
    end

    // step evaluation, committed in S_EXEC
    always_comb
    begin
        act_eff    = start_item_reg | run_active_reg;
        init_eff   = start_item_reg ? hall_item_reg : initial_hall_reg;
        moved_eff  = start_item_reg ? '0 : hall_moved_reg;
        peak_eff   = start_item_reg ? '0 : peak_reg;
        sum_eff    = start_item_reg ? '0 : sum_reg;
        count_eff  = start_item_reg ? '0 : count_reg;
        count_upd  = (count_eff != COUNT_MAX) ? count_eff + 1'b1 : count_eff;
        duty       = (duty_reg > DUTY_MAX) ? DUTY_MAX : duty_reg;
        trip       = cur_item_reg > limit_reg;
        length_hit = (CMP_W'(count_upd) >= CMP_W'(length_reg)) || (count_upd == COUNT_MAX);

        run_active_next   = run_active_reg;
        initial_hall_next = initial_hall_reg;
        hall_moved_next   = hall_moved_reg;
        peak_next         = peak_reg;
        sum_next          = sum_reg;
        count_next        = count_reg;
        res_drive_a_next  = '0;
        res_drive_b_next  = '0;
        res_drive_c_next  = '0;
        res_status_next   = ST_IDLE;
        finish            = 1'b0;

        if (act_eff)
        begin
            run_active_next   = 1'b1;
            initial_hall_next = init_eff;
            hall_moved_next   = moved_eff;
            sum_next          = sum_eff + SUM_W'(cur_item_reg);
            count_next        = count_upd;
            peak_next         = (cur_item_reg > peak_eff) ? cur_item_reg : peak_eff;
            if (trip)
            begin
                res_status_next = ST_TRIP;
                run_active_next = 1'b0;
            end
            else
            begin
                hall_moved_next = moved_eff | (hall_item_reg ^ init_eff);
                res_status_next = ST_RUN;
                unique case (hall_item_reg)
                    3'd1, 3'd5: res_drive_a_next = duty;
                    3'd2, 3'd3: res_drive_b_next = duty;
                    3'd4, 3'd6: res_drive_c_next = duty;
                    default:
                    begin
                        res_status_next = ST_BADHALL;
                        run_active_next = 1'b0;
                    end
                endcase
                if (res_status_next == ST_RUN && length_hit)
                begin
                    res_drive_a_next = '0;
                    res_drive_b_next = '0;
                    res_drive_c_next = '0;
                    res_status_next  = ST_DONE;
                    run_active_next  = 1'b0;
                    finish           = 1'b1;
                end
            end
        end
    end

    // sequencer
    assign load_out = (state_reg == S_LOAD) && (!out_valid_reg || result.ready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (sample.valid) state_next = S_EXEC;
            S_EXEC: state_next = finish ? S_DIV : S_LOAD;
            S_DIV:  if (div_stat.done) state_next = S_LOAD;
            S_LOAD: if (load_out) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    assign sample.ready  = (state_reg == S_IDLE);
    assign div_ctl.start = (state_reg == S_EXEC) && finish;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            run_active_reg   <= 1'b0;
            initial_hall_reg <= '0;
            hall_moved_reg   <= '0;
            peak_reg         <= '0;
            sum_reg          <= '0;
            count_reg        <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_EXEC)
            begin
                run_active_reg   <= run_active_next;
                initial_hall_reg <= initial_hall_next;
                hall_moved_reg   <= hall_moved_next;
                peak_reg         <= peak_next;
                sum_reg          <= sum_next;
                count_reg        <= count_next;
            end
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample.valid && sample.ready)
        begin
            start_item_reg <= sample.start_run;
            hall_item_reg  <= sample.hall_pattern;
            cur_item_reg   <= sample.phase_current_ma;
        end
        if (state_reg == S_EXEC)
        begin
            res_drive_a_reg <= res_drive_a_next;
            res_drive_b_reg <= res_drive_b_next;
            res_drive_c_reg <= res_drive_c_next;
            res_status_reg  <= res_status_next;
        end
        if (load_out)
        begin
            out_drive_a_reg <= res_drive_a_reg;
            out_drive_b_reg <= res_drive_b_reg;
            out_drive_c_reg <= res_drive_c_reg;
            out_status_reg  <= res_status_reg;
            out_peak_reg    <= peak_reg;
            out_mean_reg    <= (res_status_reg == ST_DONE) ? quotient : '0;
            out_moved_reg   <= hall_moved_reg;
        end
    end

    // the divider loads in the same cycle the accumulators take this step's sample
    hssm_div #(
        .DEN_W (COUNT_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (div_ctl),
        .stat     (div_stat),
        .dividend (sum_next),
        .divisor  (count_next),
        .quotient (quotient)
    );

    assign result.valid           = out_valid_reg;
    assign result.drive_a         = out_drive_a_reg;
    assign result.drive_b         = out_drive_b_reg;
    assign result.drive_c         = out_drive_c_reg;
    assign result.run_status      = out_status_reg;
    assign result.peak_current_ma = out_peak_reg;
    assign result.mean_current_ma = out_mean_reg;
    assign result.all_halls_moved = &out_moved_reg;
    assign result.stuck_halls     = ~out_moved_reg;

    `HSSM_ASSERT_SAME(a_idle_div_quiet, state_reg == S_IDLE, !div_stat.busy, "divider busy while idle")
    `HSSM_ASSERT_SAME(a_div_done_in_div, div_stat.done, state_reg == S_DIV, "divider done outside divide state")
    `HSSM_ASSERT_SAME(a_run_end_status, $fell(run_active_reg), res_status_reg != ST_RUN && res_status_reg != ST_IDLE, "run ended without an ending status")

endmodule

// File: tb/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import hssm_pkg::*;

    localparam cfg_idx_t CFG_SPARE   = 2'd3;   // no register behind this index
    localparam logic [15:0] COUNT_MAX = 16'hFFFF;
    localparam int   RANDOM_ITEMS     = 1860;
    localparam int   CYCLE_LIMIT      = 3_000_000;
    localparam int   TAIL_CYCLES      = 40;

    typedef struct packed {
        cur_t    drive_a;
        cur_t    drive_b;
        cur_t    drive_c;
        status_t run_status;
        cur_t    peak_current_ma;
        cur_t    mean_current_ma;
        logic    all_halls_moved;
        hall_t   stuck_halls;
    } monitor_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    hssm_sample_if sample_ch();
    hssm_result_if result_ch();
    hssm_cfg_if    cfg_ch();

    hall_six_step_test_monitor u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // predictor registers and state
    cfg_data_t       duty_reg   = 16'd0;
    cfg_data_t       limit_reg  = LIMIT_RESET;
    cfg_data_t       length_reg = LENGTH_RESET;
    logic            running    = 1'b0;
    hall_t           ref_hall   = '0;
    hall_t           moved_mask = '0;
    cur_t            peak_ma    = '0;
    logic [63:0]     sum_ma     = '0;
    logic [15:0]     n_samples  = '0;

    monitor_result_t pending_results[$];
    int              mismatches  = 0;
    int              items_sent  = 0;
    int              cycles      = 0;
    int              hold_cycles = 0;
    logic            tx_idle_on  = 1'b1;
    logic            rx_idle_on  = 1'b1;

    function automatic monitor_result_t monitor_step(logic start, hall_t hall, cur_t cur);
        monitor_result_t r;
        cur_t            duty;
        r = '0;
        r.run_status = ST_IDLE;
        duty = (duty_reg > DUTY_MAX) ? DUTY_MAX : duty_reg;
        if (start)
        begin
            running    = 1'b1;
            ref_hall   = hall;
            moved_mask = '0;
            peak_ma    = '0;
            sum_ma     = '0;
            n_samples  = '0;
        end
        if (running)
        begin
            sum_ma = sum_ma + cur;
            if (n_samples != COUNT_MAX)
                n_samples = n_samples + 1'b1;
            if (cur > peak_ma)
                peak_ma = cur;
            if (cur > limit_reg)
            begin
                r.run_status = ST_TRIP;
                running = 1'b0;
            end
            else
            begin
                moved_mask = moved_mask | (hall ^ ref_hall);
                // six-step table: one phase per valid hall pattern
                case (hall)
                    3'd1, 3'd5:
                    begin
                        r.drive_a = duty;
                        r.run_status = ST_RUN;
                    end
                    3'd2, 3'd3:
                    begin
                        r.drive_b = duty;
                        r.run_status = ST_RUN;
                    end
                    3'd4, 3'd6:
                    begin
                        r.drive_c = duty;
                        r.run_status = ST_RUN;
                    end
                    default:
                    begin
                        r.run_status = ST_BADHALL;
                        running = 1'b0;
                    end
                endcase
                if (r.run_status == ST_RUN &&
                    (n_samples >= length_reg || n_samples == COUNT_MAX))
                begin
                    r.drive_a = '0;
                    r.drive_b = '0;
                    r.drive_c = '0;
                    r.run_status = ST_DONE;
                    r.mean_current_ma = cur_t'(sum_ma / n_samples);
                    running = 1'b0;
                end
            end
        end
        r.peak_current_ma = peak_ma;
        r.all_halls_moved = (moved_mask == 3'b111);
        r.stuck_halls     = ~moved_mask;
        return r;
    endfunction

    // mostly short idles, now and then a long one
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 2);
        else if (r < 92)
            return $urandom_range(3, 6);
        else
            return $urandom_range(15, 40);
    endfunction

    function automatic hall_t valid_hall();
        return hall_t'($urandom_range(1, 6));
    endfunction

    function automatic cur_t current_within_limit();
        if ($urandom_range(0, 19) == 0)
            return limit_reg;
        return cur_t'($urandom_range(0, limit_reg));
    endfunction

    function automatic cur_t current_over_limit();
        return cur_t'($urandom_range(limit_reg + 1, 65535));
    endfunction

    task automatic send_sample(logic start, hall_t hall, cur_t cur);
        int gap;
        gap = 0;
        if (tx_idle_on && $urandom_range(0, 99) < 30)
            gap = idle_length();
        if (gap > 0)
        begin
            @(negedge clk);
            sample_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        sample_ch.valid            <= 1'b1;
        sample_ch.start_run        <= start;
        sample_ch.hall_pattern     <= hall;
        sample_ch.phase_current_ma <= cur;
        do
            @(posedge clk);
        while (!sample_ch.ready);
        pending_results.push_back(monitor_step(start, hall, cur));
        items_sent++;
    endtask

    // stop offering and wait until every outstanding result has arrived
    task automatic drain();
        @(negedge clk);
        sample_ch.valid <= 1'b0;
        wait (pending_results.size() == 0);
    endtask

    task automatic write_reg(cfg_idx_t idx, cfg_data_t value);
        drain();
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        case (idx)
            CFG_DUTY:   duty_reg   = value;
            CFG_LIMIT:  limit_reg  = value;
            CFG_LENGTH: length_reg = value;
            default:    ;
        endcase
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic configure(cfg_data_t duty, cfg_data_t limit, cfg_data_t length);
        write_reg(CFG_DUTY, duty);
        write_reg(CFG_LIMIT, limit);
        write_reg(CFG_LENGTH, length);
    endtask

    // receiver: random stalls, plus a forced hold counted down here
    initial
    begin
        int left;
        left = 0;
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!rst_n)
                result_ch.ready <= 1'b0;
            else if (hold_cycles > 0)
            begin
                result_ch.ready <= 1'b0;
                hold_cycles--;
            end
            else if (left > 0)
            begin
                result_ch.ready <= 1'b0;
                left--;
            end
            else if (rx_idle_on && $urandom_range(0, 99) < 20)
            begin
                result_ch.ready <= 1'b0;
                left = idle_length() - 1;
            end
            else
                result_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        monitor_result_t seen;
        monitor_result_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            seen.drive_a         = result_ch.drive_a;
            seen.drive_b         = result_ch.drive_b;
            seen.drive_c         = result_ch.drive_c;
            seen.run_status      = result_ch.run_status;
            seen.peak_current_ma = result_ch.peak_current_ma;
            seen.mean_current_ma = result_ch.mean_current_ma;
            seen.all_halls_moved = result_ch.all_halls_moved;
            seen.stuck_halls     = result_ch.stuck_halls;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transaction at cycle %0d", cycles);
            end
            else
            begin
                want = pending_results.pop_front();
                if (seen !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch at cycle %0d", cycles);
                        $display("  exp a=%0d b=%0d c=%0d st=%0d peak=%0d mean=%0d all=%0b stuck=%03b",
                                 want.drive_a, want.drive_b, want.drive_c, want.run_status,
                                 want.peak_current_ma, want.mean_current_ma,
                                 want.all_halls_moved, want.stuck_halls);
                        $display("  got a=%0d b=%0d c=%0d st=%0d peak=%0d mean=%0d all=%0b stuck=%03b",
                                 seen.drive_a, seen.drive_b, seen.drive_c, seen.run_status,
                                 seen.peak_current_ma, seen.mean_current_ma,
                                 seen.all_halls_moved, seen.stuck_halls);
                    end
                end
            end
        end
    end

    always @(posedge clk)
        cycles <= cycles + 1;

    initial
    begin
        wait (cycles >= CYCLE_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    // reset register values: duty 0, limit 10000, length 1000
    task automatic test_reset_defaults();
        send_sample(1'b0, 3'd0, 16'd0);
        send_sample(1'b0, 3'd7, 16'hFFFF);
        send_sample(1'b1, 3'd3, 16'd10000);
        send_sample(1'b0, 3'd1, 16'd10001);
        send_sample(1'b1, 3'd2, 16'd50);
        send_sample(1'b0, 3'd6, 16'd70);
        send_sample(1'b0, 3'd0, 16'd90);
    endtask

    task automatic test_directed_cases();
        configure(16'hFFFF, 16'd5000, 16'd4);
        write_reg(CFG_SPARE, 16'hFFFF);
        // full run to completion, current at the limit does not trip
        send_sample(1'b1, 3'd1, 16'd0);
        send_sample(1'b0, 3'd3, 16'd5000);
        send_sample(1'b0, 3'd6, 16'd100);
        send_sample(1'b0, 3'd5, 16'd7);
        send_sample(1'b0, 3'd7, 16'hFFFF);
        // trip on the first sample
        send_sample(1'b1, 3'd2, 16'd5001);
        send_sample(1'b0, 3'd4, 16'd1);
        // invalid hall patterns
        send_sample(1'b1, 3'd4, 16'd10);
        send_sample(1'b0, 3'd0, 16'd20);
        send_sample(1'b1, 3'd6, 16'd30);
        send_sample(1'b0, 3'd7, 16'd40);
        // restart while running
        send_sample(1'b1, 3'd1, 16'd300);
        send_sample(1'b0, 3'd2, 16'd400);
        send_sample(1'b1, 3'd4, 16'd11);
        send_sample(1'b0, 3'd3, 16'd13);
        send_sample(1'b0, 3'd5, 16'd17);
        send_sample(1'b0, 3'd6, 16'd19);
        // zero length completes on the first sample
        write_reg(CFG_LENGTH, 16'd0);
        send_sample(1'b1, 3'd5, 16'd4999);
        write_reg(CFG_LENGTH, 16'd1);
        send_sample(1'b1, 3'd2, 16'd1234);
    endtask

    task automatic test_duty_clamp();
        cfg_data_t duties[6] = '{16'd0, 16'd1, 16'd32767, 16'd32768, 16'd32769, 16'hFFFF};
        configure(16'd0, 16'hFFFF, 16'd3);
        foreach (duties[i])
        begin
            write_reg(CFG_DUTY, duties[i]);
            send_sample(1'b1, valid_hall(), cur_t'($urandom));
            send_sample(1'b0, valid_hall(), cur_t'($urandom));
        end
    endtask

    // receiver holds off while the sender keeps offering
    task automatic test_backpressure();
        configure(16'd20000, 16'hFFFF, 16'hFFFF);
        tx_idle_on = 1'b0;
        hold_cycles = 300;
        send_sample(1'b1, valid_hall(), cur_t'($urandom));
        repeat (40)
            send_sample(1'b0, valid_hall(), cur_t'($urandom));
        send_sample(1'b0, 3'd7, 16'd0);
        tx_idle_on = 1'b1;
    endtask

    // sender stops mid-run until all results are in, then the run continues
    task automatic test_sender_pause();
        configure(16'd12345, 16'd40000, 16'd12);
        send_sample(1'b1, 3'd1, current_within_limit());
        repeat (5)
            send_sample(1'b0, valid_hall(), current_within_limit());
        drain();
        repeat (6)
            send_sample(1'b0, valid_hall(), current_within_limit());
    endtask

    task automatic randomize_config();
        cfg_data_t duty;
        cfg_data_t limit;
        cfg_data_t length;
        int        r;
        case ($urandom_range(0, 5))
            0: duty = 16'd0;
            1: duty = 16'hFFFF;
            2: duty = DUTY_MAX;
            3: duty = DUTY_MAX + 1'b1;
            default: duty = cfg_data_t'($urandom);
        endcase
        r = $urandom_range(0, 9);
        if (r == 0)
            limit = 16'hFFFF;
        else if (r == 1)
            limit = 16'd0;
        else if (r < 4)
            limit = cfg_data_t'($urandom_range(1, 100));
        else
            limit = cfg_data_t'($urandom_range(1000, 65535));
        r = $urandom_range(0, 19);
        if (r == 0)
            length = 16'd0;
        else if (r == 1)
            length = 16'hFFFF;
        else if (r < 4)
            length = 16'd1;
        else
            length = cfg_data_t'($urandom_range(2, 30));
        configure(duty, limit, length);
    endtask

    task automatic random_run();
        int steps;
        int r;
        send_sample(1'b1, valid_hall(), current_within_limit());
        steps = $urandom_range(1, 40);
        while (running && steps > 0)
        begin
            steps--;
            r = $urandom_range(0, 99);
            if (r < 3 && limit_reg != 16'hFFFF)
                send_sample(1'b0, valid_hall(), current_over_limit());
            else if (r < 6)
                send_sample(1'b0, ($urandom_range(0, 1) != 0) ? 3'd7 : 3'd0,
                            current_within_limit());
            else if (r < 8)
                send_sample(1'b1, valid_hall(), current_within_limit());
            else
                send_sample(1'b0, valid_hall(), current_within_limit());
        end
    endtask

    task automatic test_random_runs();
        int runs;
        int stop_at;
        runs = 0;
        stop_at = items_sent + RANDOM_ITEMS;
        while (items_sent < stop_at)
        begin
            if (runs % 8 == 0)
            begin
                randomize_config();
                tx_idle_on = ($urandom_range(0, 3) != 0);
                rx_idle_on = ($urandom_range(0, 3) != 0);
            end
            runs++;
            // a stray step without start_run, outside a run or within one left open
            if ($urandom_range(0, 9) == 0)
                send_sample(1'b0, hall_t'($urandom_range(0, 7)), cur_t'($urandom));
            random_run();
            if ($urandom_range(0, 19) == 0)
                drain();
        end
    endtask

    initial
    begin
        sample_ch.valid            = 1'b0;
        sample_ch.start_run        = 1'b0;
        sample_ch.hall_pattern     = '0;
        sample_ch.phase_current_ma = '0;
        cfg_ch.valid               = 1'b0;
        cfg_ch.index               = CFG_DUTY;
        cfg_ch.data                = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_directed_cases();
        test_duty_clamp();
        test_backpressure();
        test_sender_pause();
        test_random_runs();

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
